>>> design/mandelbrot_escape_time_pixel_unit_assert.svh
// assertion macros for the mandelbrot escape time pixel unit
// no dependencies; included by the modules that carry concurrent checks
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbe assertion failed");
// next-cycle implication
`define MBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbe assertion failed");
`else
`define MBE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MBE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mbe_pkg.sv
// shared constants, types and helper functions of the mandelbrot pixel unit
// no dependencies; imported by every module of the block
package mbe_pkg;

    localparam int COORD_BITS     = 32;
    localparam int FRAC_BITS      = COORD_BITS - 4;
    localparam int COUNT_BITS     = 16;
    localparam int INDEX_BITS     = 12;
    localparam int SIZE_BITS      = 13;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int DELTA_BITS     = COORD_BITS + 1;
    localparam int MUL_BITS       = DELTA_BITS;
    localparam int PROD_BITS      = 2 * MUL_BITS;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int WIDE_BITS      = COORD_BITS + INDEX_BITS + 2;
    localparam int DIV_STEPS      = COORD_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    localparam logic [SQ_BITS-1:0] ESCAPE_BOUND = SQ_BITS'(4) << (2 * FRAC_BITS);

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_REAL_MIN   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REAL_MAX   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAG_MIN   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAG_MAX   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = 3'd6;

    localparam logic [COORD_BITS-1:0] RESET_REAL_MIN   = 32'hE000_0000;
    localparam logic [COORD_BITS-1:0] RESET_REAL_MAX   = 32'h1000_0000;
    localparam logic [COORD_BITS-1:0] RESET_IMAG_MIN   = 32'hE800_0000;
    localparam logic [COORD_BITS-1:0] RESET_IMAG_MAX   = 32'h1800_0000;
    localparam logic [SIZE_BITS-1:0]  RESET_WIDTH      = 13'd640;
    localparam logic [SIZE_BITS-1:0]  RESET_HEIGHT     = 13'd480;
    localparam logic [COUNT_BITS-1:0] RESET_ITER_LIMIT = 16'd256;

    typedef struct packed {
        logic                  start;
        logic [DELTA_BITS-1:0] dividend;
        logic [SIZE_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DELTA_BITS-1:0] quotient;
    } div_rsp_t;

    function automatic logic [WIDE_BITS-1:0] sext_coord(input logic [COORD_BITS-1:0] v);
        return {{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // clamp a wide signed value to the coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-COORD_BITS:0] upper;
        upper = v[WIDE_BITS-1:COORD_BITS-1];
        if (upper == '0 || upper == '1)
            return v[COORD_BITS-1:0];
        else if (v[WIDE_BITS-1])
            return COORD_MIN;
        else
            return COORD_MAX;
    endfunction

endpackage

>>> design/mbe_divider.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
// depends on mbe_pkg for widths and the request/response structs
module mbe_divider import mbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_STEPS-1:0]    quo_reg, quo_next;
    logic [SIZE_BITS-1:0]    rem_reg, rem_next;
    logic [SIZE_BITS-1:0]    divisor_reg, divisor_next;
    logic                    neg_reg, neg_next;

    logic [DELTA_BITS-1:0] mag;
    logic [SIZE_BITS:0]    rem_shift;
    logic [SIZE_BITS:0]    rem_sub;
    logic                  fits;
    logic [DELTA_BITS-1:0] quo_ext;

    assign mag       = req.dividend[DELTA_BITS-1] ? -req.dividend : req.dividend;
    assign rem_shift = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = DIV_CNT_BITS'(DIV_STEPS - 1);
            quo_next     = mag[DIV_STEPS-1:0];
            rem_next     = '0;
            divisor_next = req.divisor;
            neg_next     = req.dividend[DELTA_BITS-1];
        end
        else if (busy_reg)
        begin
            // dividend bits shift out on top while quotient bits shift in below
            quo_next = {quo_reg[DIV_STEPS-2:0], fits};
            rem_next = fits ? rem_sub[SIZE_BITS-1:0] : rem_shift[SIZE_BITS-1:0];
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    assign quo_ext      = {1'b0, quo_reg};
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -quo_ext : quo_ext;

endmodule

>>> design/mbe_multiplier.sv
// shared signed multiplier with a registered product
// depends on mbe_pkg for operand and product widths
module mbe_multiplier import mbe_pkg::*;
(
    input  logic                        clk,
    input  logic signed [MUL_BITS-1:0]  a,
    input  logic signed [MUL_BITS-1:0]  b,
    output logic signed [PROD_BITS-1:0] prod
);

    logic signed [PROD_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> design/mandelbrot_escape_time_pixel_unit.sv
// top level of the mandelbrot escape time pixel unit: registers, sequencer, output beat
// depends on mbe_pkg, mbe_divider, mbe_multiplier and the assertion macro header
//
// usage:
//   input channel (in_valid / in_stall) carries one pixel's row_index and column_index
//   output channel (out_valid / out_stall) returns out_row, out_column, escape_count
//   a beat moves at a clock edge with valid high and stall low on that channel
//   configuration is written through cfg_write / cfg_index / cfg_data while idle
// timing:
//   one pixel is worked at a time; in_stall is high from accept until the result
//   is handed to the output register
//   map to the complex plane: S_MAP_RE, S_MAP_IM, S_MAP_END on the shared multiplier
//   each iteration: three products through the one multiplier (S_RR, S_II, S_RI), then update
//   the next pixel can be accepted in the cycle after a result is handed to the output register
//   after reset or a configuration write the axis steps are rebuilt by the bit-serial
//   divider before the next pixel
// reset: configuration returns to its defaults, the output register empties
// stall: the finished result waits in the output register; the next pixel is accepted
//   meanwhile, and a later result waits in the sequencer until the register frees
`include "mandelbrot_escape_time_pixel_unit_assert.svh"
module mandelbrot_escape_time_pixel_unit import mbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [INDEX_BITS-1:0]     row_index,
    input  logic [INDEX_BITS-1:0]     column_index,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [INDEX_BITS-1:0]     out_row,
    output logic [INDEX_BITS-1:0]     out_column,
    output logic [COUNT_BITS-1:0]     escape_count,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV_RE  = 4'd1;
    localparam logic [3:0] S_DIV_IM  = 4'd2;
    localparam logic [3:0] S_MAP_RE  = 4'd3;
    localparam logic [3:0] S_MAP_IM  = 4'd4;
    localparam logic [3:0] S_MAP_END = 4'd5;
    localparam logic [3:0] S_RR      = 4'd6;
    localparam logic [3:0] S_II      = 4'd7;
    localparam logic [3:0] S_RI      = 4'd8;
    localparam logic [3:0] S_UPD     = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // configuration registers
    logic [COORD_BITS-1:0] real_min_reg, real_max_reg, imag_min_reg, imag_max_reg;
    logic [SIZE_BITS-1:0]  width_reg, height_reg;
    logic [COUNT_BITS-1:0] iter_limit_reg;

    // sequencer control
    logic [3:0] state_reg, state_next;
    logic       deltas_ok_reg, deltas_ok_next;
    logic       out_valid_reg, out_valid_next;

    // sequencer payload
    logic [INDEX_BITS-1:0] row_reg, row_next;
    logic [INDEX_BITS-1:0] col_reg, col_next;
    logic [COUNT_BITS-1:0] limit_reg, limit_next;
    logic [DELTA_BITS-1:0] delta_re_reg, delta_re_next;
    logic [DELTA_BITS-1:0] delta_im_reg, delta_im_next;
    logic [COORD_BITS-1:0] cr_reg, cr_next;
    logic [COORD_BITS-1:0] ci_reg, ci_next;
    logic [COORD_BITS-1:0] zr_reg, zr_next;
    logic [COORD_BITS-1:0] zi_reg, zi_next;
    logic [SQ_BITS-1:0]    r2_reg, r2_next;
    logic [SQ_BITS-1:0]    diff_reg, diff_next;
    logic                  esc_reg, esc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [INDEX_BITS-1:0] out_row_reg, out_row_next;
    logic [INDEX_BITS-1:0] out_col_reg, out_col_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;

    logic                        accept;
    logic [DELTA_BITS-1:0]       real_span, imag_span;
    logic [SIZE_BITS-1:0]        width_div, height_div;
    div_req_t                    div_req;
    div_rsp_t                    div_rsp;
    logic signed [MUL_BITS-1:0]  mul_a, mul_b;
    logic signed [PROD_BITS-1:0] prod;
    logic [SQ_BITS-1:0]          sq_prod;
    logic [SQ_BITS-1:0]          diff_shr, cross_shr;
    logic [WIDE_BITS-1:0]        map_re_sum, map_im_sum, nr_sum, ni_sum;
    logic [COUNT_BITS-1:0]       count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg   <= RESET_REAL_MIN;
            real_max_reg   <= RESET_REAL_MAX;
            imag_min_reg   <= RESET_IMAG_MIN;
            imag_max_reg   <= RESET_IMAG_MAX;
            width_reg      <= RESET_WIDTH;
            height_reg     <= RESET_HEIGHT;
            iter_limit_reg <= RESET_ITER_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REAL_MIN:   real_min_reg   <= cfg_data[COORD_BITS-1:0];
                REG_REAL_MAX:   real_max_reg   <= cfg_data[COORD_BITS-1:0];
                REG_IMAG_MIN:   imag_min_reg   <= cfg_data[COORD_BITS-1:0];
                REG_IMAG_MAX:   imag_max_reg   <= cfg_data[COORD_BITS-1:0];
                REG_WIDTH:      width_reg      <= cfg_data[SIZE_BITS-1:0];
                REG_HEIGHT:     height_reg     <= cfg_data[SIZE_BITS-1:0];
                REG_ITER_LIMIT: iter_limit_reg <= cfg_data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign real_span  = {real_max_reg[COORD_BITS-1], real_max_reg}
                      - {real_min_reg[COORD_BITS-1], real_min_reg};
    assign imag_span  = {imag_max_reg[COORD_BITS-1], imag_max_reg}
                      - {imag_min_reg[COORD_BITS-1], imag_min_reg};
    // a size of zero divides like one
    assign width_div  = (width_reg == '0) ? SIZE_BITS'(1) : width_reg;
    assign height_div = (height_reg == '0) ? SIZE_BITS'(1) : height_reg;

    // real step starts on the accepting beat, imaginary step when the real one is done
    assign div_req.start    = (accept && !deltas_ok_reg)
                            || (state_reg == S_DIV_RE && div_rsp.done);
    assign div_req.dividend = (state_reg == S_IDLE) ? real_span : imag_span;
    assign div_req.divisor  = (state_reg == S_IDLE) ? width_div : height_div;

    mbe_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        unique case (state_reg)
            S_MAP_RE:
            begin
                mul_a = $signed(delta_re_reg);
                mul_b = $signed({{(MUL_BITS-INDEX_BITS){1'b0}}, col_reg});
            end
            S_MAP_IM:
            begin
                mul_a = $signed(delta_im_reg);
                mul_b = $signed({{(MUL_BITS-INDEX_BITS){1'b0}}, row_reg});
            end
            S_RR:
            begin
                mul_a = $signed({zr_reg[COORD_BITS-1], zr_reg});
                mul_b = $signed({zr_reg[COORD_BITS-1], zr_reg});
            end
            S_II:
            begin
                mul_a = $signed({zi_reg[COORD_BITS-1], zi_reg});
                mul_b = $signed({zi_reg[COORD_BITS-1], zi_reg});
            end
            S_RI:
            begin
                mul_a = $signed({zr_reg[COORD_BITS-1], zr_reg});
                mul_b = $signed({zi_reg[COORD_BITS-1], zi_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mbe_multiplier u_multiplier
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign sq_prod    = prod[SQ_BITS-1:0];
    assign map_re_sum = sext_coord(real_min_reg) + prod[WIDE_BITS-1:0];
    assign map_im_sum = sext_coord(imag_min_reg) + prod[WIDE_BITS-1:0];
    // floor back to the fixed point grid, the cross term keeps one extra bit for 2*zr*zi
    assign diff_shr   = $signed(diff_reg) >>> FRAC_BITS;
    assign cross_shr  = $signed(sq_prod) >>> (FRAC_BITS - 1);
    assign nr_sum     = diff_shr[WIDE_BITS-1:0] + sext_coord(cr_reg);
    assign ni_sum     = cross_shr[WIDE_BITS-1:0] + sext_coord(ci_reg);
    assign count_inc  = count_reg + COUNT_BITS'(1);

    always_comb
    begin
        state_next     = state_reg;
        deltas_ok_next = deltas_ok_reg;
        out_valid_next = out_valid_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        limit_next     = limit_reg;
        delta_re_next  = delta_re_reg;
        delta_im_next  = delta_im_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        r2_next        = r2_reg;
        diff_next      = diff_reg;
        esc_next       = esc_reg;
        count_next     = count_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_count_next = out_count_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next   = row_index;
                    col_next   = column_index;
                    limit_next = iter_limit_reg;
                    state_next = deltas_ok_reg ? S_MAP_RE : S_DIV_RE;
                end
            end
            S_DIV_RE:
            begin
                if (div_rsp.done)
                begin
                    delta_re_next = div_rsp.quotient;
                    state_next    = S_DIV_IM;
                end
            end
            S_DIV_IM:
            begin
                if (div_rsp.done)
                begin
                    delta_im_next  = div_rsp.quotient;
                    deltas_ok_next = 1'b1;
                    state_next     = S_MAP_RE;
                end
            end
            S_MAP_RE:
                state_next = S_MAP_IM;
            S_MAP_IM:
            begin
                cr_next    = sat_coord(map_re_sum);
                state_next = S_MAP_END;
            end
            S_MAP_END:
            begin
                ci_next    = sat_coord(map_im_sum);
                zr_next    = '0;
                zi_next    = '0;
                count_next = '0;
                state_next = (limit_reg == '0) ? S_DONE : S_RR;
            end
            S_RR:
                state_next = S_II;
            S_II:
            begin
                r2_next    = sq_prod;
                state_next = S_RI;
            end
            S_RI:
            begin
                // squares are never negative and stay at or below 2^62, so no wrap here
                diff_next  = r2_reg - sq_prod;
                esc_next   = (r2_reg + sq_prod) > ESCAPE_BOUND;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (esc_reg)
                    state_next = S_DONE;
                else
                begin
                    zr_next    = sat_coord(nr_sum);
                    zi_next    = sat_coord(ni_sum);
                    count_next = count_inc;
                    state_next = (count_inc == limit_reg) ? S_DONE : S_RR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    out_count_next = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // any register write makes the cached axis steps stale
        if (cfg_write)
            deltas_ok_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            deltas_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deltas_ok_reg <= deltas_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        limit_reg     <= limit_next;
        delta_re_reg  <= delta_re_next;
        delta_im_reg  <= delta_im_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        r2_reg        <= r2_next;
        diff_reg      <= diff_next;
        esc_reg       <= esc_next;
        count_reg     <= count_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_column   = out_col_reg;
    assign escape_count = out_count_reg;

    `MBE_ASSERT_IMP(a_count_below_limit, clk, rst_n, state_reg == S_UPD,
        count_reg < limit_reg)
    `MBE_ASSERT_IMP(a_div_done_when_waiting, clk, rst_n, div_rsp.done,
        state_reg == S_DIV_RE || state_reg == S_DIV_IM)
    `MBE_ASSERT_NXT(a_out_loads_only_from_done, clk, rst_n,
        !out_valid_reg && state_reg != S_DONE, !out_valid_reg)
    `MBE_ASSERT_NXT(a_update_leads_on, clk, rst_n, state_reg == S_UPD,
        state_reg == S_RR || state_reg == S_DONE)

endmodule
